FILE: hw/rtl/ges_pkg.sv
package ges_pkg;

  localparam int BOX_W_W    = 6;
  localparam int BOX_H_W    = 10;
  localparam int WIN_W      = 14;
  localparam int CXY_W      = 13;
  localparam int CRD_W      = 15;
  localparam int PIXEL_BITS = 16;
  localparam int SUM_W      = 50;
  localparam int SHARP_W    = 33;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [BOX_W_W-1:0] BOX_W_RESET = 6'd15;
  localparam logic [BOX_H_W-1:0] BOX_H_RESET = 10'd15;
  localparam logic [WIN_W-1:0]   WIN_RESET   = 14'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_WIDTH     = 2'd0,
    REG_BOX_HEIGHT    = 2'd1,
    REG_WINDOW_WIDTH  = 2'd2,
    REG_WINDOW_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_PIXEL = 1'b1
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_BOUNDS = 2'd1,
    STAT_DEGEN  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_SUM,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic start;
    logic pixel;
  } grad_ctl_t;

  typedef struct packed {
    logic at_last;
    logic sq_valid;
  } grad_sts_t;

endpackage

FILE: hw/rtl/ges_if.sv
interface ges_in_if;
  logic                            valid;
  logic                            ready;
  logic                            mode;
  logic [ges_pkg::CXY_W-1:0]       center_x;
  logic [ges_pkg::CXY_W-1:0]       center_y;
  logic [ges_pkg::PIXEL_BITS-1:0]  pixel_value;

  modport source (output valid, mode, center_x, center_y, pixel_value, input ready);
  modport sink (input valid, mode, center_x, center_y, pixel_value, output ready);
endinterface

interface ges_out_if;
  logic                         valid;
  logic                         ready;
  logic [ges_pkg::SHARP_W-1:0]  sharpness;
  logic [ges_pkg::STAT_W-1:0]   status;

  modport source (output valid, sharpness, status, input ready);
  modport sink (input valid, sharpness, status, output ready);
endinterface

FILE: hw/rtl/ges_ram.sv
module ges_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/ges_grad.sv
module ges_grad #(
  parameter int MAX_BOX_WIDTH  = 64,
  parameter int MAX_BOX_HEIGHT = 1024,
  parameter int PIXEL_BITS     = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ges_pkg::grad_ctl_t                ctl,
  input  logic [$clog2(MAX_BOX_WIDTH)-1:0]  w_last_in,
  input  logic [$clog2(MAX_BOX_HEIGHT)-1:0] h_last_in,
  input  logic [PIXEL_BITS-1:0]             pixel,
  output ges_pkg::grad_sts_t                sts,
  output logic [2*PIXEL_BITS-1:0]           sq_x,
  output logic [2*PIXEL_BITS-1:0]           sq_y
);

  localparam int COL_W = $clog2(MAX_BOX_WIDTH);
  localparam int ROW_W = $clog2(MAX_BOX_HEIGHT);
  localparam int SQ_W  = 2 * PIXEL_BITS;

  logic [COL_W-1:0]      col, col_next, w_last;
  logic [ROW_W-1:0]      row, row_next, h_last;
  logic [PIXEL_BITS-1:0] left, above, dx, dy;
  logic                  sq_valid, col_end, en_x, en_y;

  assign col_end = (col == w_last);
  assign en_x    = (col != '0) && (row != h_last);
  assign en_y    = (row != '0) && !col_end;
  assign dx      = (pixel >= left) ? pixel - left : left - pixel;
  assign dy      = (pixel >= above) ? pixel - above : above - pixel;

  always_comb begin
    col_next = col;
    row_next = row;
    if (ctl.start) begin
      col_next = '0;
      row_next = '0;
    end else if (ctl.pixel) begin
      if (col_end) begin
        col_next = '0;
        row_next = (row == h_last) ? '0 : row + 1'b1;
      end else begin
        col_next = col + 1'b1;
      end
    end
  end

  ges_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_BOX_WIDTH)
  ) u_row_store (
    .clk   (clk),
    .we    (ctl.pixel),
    .waddr (col),
    .wdata (pixel),
    .raddr (col_next),
    .rdata (above)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      sq_valid <= 1'b0;
    end else begin
      col      <= col_next;
      row      <= row_next;
      sq_valid <= ctl.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      w_last <= w_last_in;
      h_last <= h_last_in;
    end
    if (ctl.pixel) begin
      left <= pixel;
      sq_x <= en_x ? SQ_W'(dx) * SQ_W'(dx) : '0;
      sq_y <= en_y ? SQ_W'(dy) * SQ_W'(dy) : '0;
    end
  end

  assign sts.at_last  = col_end && (row == h_last);
  assign sts.sq_valid = sq_valid;

endmodule

FILE: hw/rtl/ges_div.sv
module ges_div #(
  parameter int DEN_W = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ges_pkg::SUM_W-1:0]   dividend,
  input  logic [DEN_W-1:0]            divisor,
  output logic                        done,
  output logic [ges_pkg::SHARP_W-1:0] quotient
);

  localparam int CNT_W = $clog2(ges_pkg::SUM_W);

  logic                      busy;
  logic [CNT_W-1:0]          cnt;
  logic [ges_pkg::SUM_W-1:0] dvd;
  logic [DEN_W-1:0]          rem;
  logic [DEN_W:0]            trial;
  logic                      fits;

  assign trial = {rem, dvd[ges_pkg::SUM_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ges_pkg::SUM_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= dvd << 1;
      rem      <= fits ? DEN_W'(trial - {1'b0, divisor}) : DEN_W'(trial);
      quotient <= {quotient[ges_pkg::SHARP_W-2:0], fits};
    end
  end

endmodule

FILE: hw/rtl/gradient_energy_sharpness.sv
// Gradient-energy sharpness of an image box.
// The input channel carries start items (mode 0, with the box centre) and box
// pixels (mode 1, raster order). A start that puts the box outside the window
// or gives a width or height of one returns its status at once; otherwise it
// opens the box. Pixels without an open box are dropped.
// Pixels are taken one per cycle unless the input is held off. After the
// transfer of the last pixel of a box the input is held off while the
// squared-gradient sum is divided by (w-1)(h-1) in a one-bit-per-cycle
// divider working through the 50-bit sum; the result is then registered.
// A start item that fails its check answers in the next cycle.
// The output is a single register. While a result waits untaken, the input
// is taken only in the cycle in which the receiver takes that result.
// Configuration writes go through cfg_write, cfg_index and cfg_data and take
// effect at the next start item.
// Reset restores the register defaults and closes any open box; the line
// buffer needs no clearing, since the first row of a box fills it.
module gradient_energy_sharpness #(
  parameter int MAX_BOX_WIDTH  = 64,
  parameter int MAX_BOX_HEIGHT = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  ges_in_if.sink                           in_ch,
  ges_out_if.source                        out_ch,
  input  logic                             cfg_write,
  input  logic [ges_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ges_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int COL_W = $clog2(MAX_BOX_WIDTH);
  localparam int ROW_W = $clog2(MAX_BOX_HEIGHT);
  localparam int DEN_W = COL_W + ROW_W;
  localparam int SQ_W  = 2 * ges_pkg::PIXEL_BITS;
  localparam int CAP_W = (MAX_BOX_WIDTH - 2) | 1;
  localparam int CAP_H = (MAX_BOX_HEIGHT - 2) | 1;
  localparam int WS_W  = (COL_W > ges_pkg::BOX_W_W) ? COL_W : ges_pkg::BOX_W_W;
  localparam int HS_W  = (ROW_W > ges_pkg::BOX_H_W) ? ROW_W : ges_pkg::BOX_H_W;

  logic [ges_pkg::BOX_W_W-1:0] box_w;
  logic [ges_pkg::BOX_H_W-1:0] box_h;
  logic [ges_pkg::WIN_W-1:0]   window_width, window_height;

  ges_pkg::state_t state, state_next;

  logic                        box_active, in_ready, div_start, div_done;
  logic                        in_fire, start_acc, start_ok, pix_acc, oob, degen, load_res;
  logic [WS_W-1:0]             w_odd, w_size;
  logic [HS_W-1:0]             h_odd, h_size;
  logic [COL_W-1:0]            w_last_s;
  logic [ROW_W-1:0]            h_last_s;
  logic [ges_pkg::CRD_W-1:0]   half_w, half_h, cx, cy;
  logic [DEN_W-1:0]            den;
  logic [ges_pkg::SUM_W-1:0]   sum, sum_next;
  logic [ges_pkg::SHARP_W-1:0] quotient;
  logic [SQ_W-1:0]             sq_x, sq_y;
  logic                        out_valid;
  logic [ges_pkg::SHARP_W-1:0] sharpness;
  logic [ges_pkg::STAT_W-1:0]  status;
  ges_pkg::grad_ctl_t          ctl;
  ges_pkg::grad_sts_t          sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_w         <= ges_pkg::BOX_W_RESET;
      box_h         <= ges_pkg::BOX_H_RESET;
      window_width  <= ges_pkg::WIN_RESET;
      window_height <= ges_pkg::WIN_RESET;
    end else if (cfg_write) begin
      case (ges_pkg::cfg_reg_t'(cfg_index))
        ges_pkg::REG_BOX_WIDTH: begin
          box_w <= cfg_data[ges_pkg::BOX_W_W-1:0];
        end
        ges_pkg::REG_BOX_HEIGHT: begin
          box_h <= cfg_data[ges_pkg::BOX_H_W-1:0];
        end
        ges_pkg::REG_WINDOW_WIDTH: begin
          window_width <= cfg_data;
        end
        ges_pkg::REG_WINDOW_HEIGHT: begin
          window_height <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Even sizes round up to odd, then clip to the largest odd size that fits.
  assign w_odd    = WS_W'({box_w[ges_pkg::BOX_W_W-1:1], 1'b1});
  assign h_odd    = HS_W'({box_h[ges_pkg::BOX_H_W-1:1], 1'b1});
  assign w_size   = (w_odd > WS_W'(CAP_W)) ? WS_W'(CAP_W) : w_odd;
  assign h_size   = (h_odd > HS_W'(CAP_H)) ? HS_W'(CAP_H) : h_odd;
  assign w_last_s = COL_W'(w_size - 1'b1);
  assign h_last_s = ROW_W'(h_size - 1'b1);
  assign half_w   = ges_pkg::CRD_W'(w_size >> 1);
  assign half_h   = ges_pkg::CRD_W'(h_size >> 1);
  assign cx       = ges_pkg::CRD_W'(in_ch.center_x);
  assign cy       = ges_pkg::CRD_W'(in_ch.center_y);

  assign oob = (cx < half_w) || (cx + half_w >= ges_pkg::CRD_W'(window_width)) ||
               (cy < half_h) || (cy + half_h >= ges_pkg::CRD_W'(window_height));
  assign degen = (w_last_s == '0) || (h_last_s == '0);

  assign in_fire   = in_ch.valid && in_ready;
  assign start_acc = in_fire && (in_ch.mode == ges_pkg::MODE_START);
  assign start_ok  = start_acc && !oob && !degen;
  assign pix_acc   = in_fire && (in_ch.mode == ges_pkg::MODE_PIXEL) && box_active;
  assign load_res  = (start_acc && (oob || degen)) || ((state == ges_pkg::ST_DIV) && div_done);

  assign ctl.start = start_ok;
  assign ctl.pixel = pix_acc;

  ges_grad #(
    .MAX_BOX_WIDTH  (MAX_BOX_WIDTH),
    .MAX_BOX_HEIGHT (MAX_BOX_HEIGHT),
    .PIXEL_BITS     (ges_pkg::PIXEL_BITS)
  ) u_grad (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .w_last_in (w_last_s),
    .h_last_in (h_last_s),
    .pixel     (in_ch.pixel_value),
    .sts       (sts),
    .sq_x      (sq_x),
    .sq_y      (sq_y)
  );

  assign sum_next = sum + ges_pkg::SUM_W'(sq_x) + ges_pkg::SUM_W'(sq_y);

  ges_div #(
    .DEN_W (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (den),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ges_pkg::ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    case (state)
      ges_pkg::ST_RUN: begin
        in_ready = !out_valid || out_ch.ready;
        if (pix_acc && sts.at_last) begin
          state_next = ges_pkg::ST_SUM;
        end
      end
      ges_pkg::ST_SUM: begin
        div_start  = 1'b1;
        state_next = ges_pkg::ST_DIV;
      end
      ges_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = ges_pkg::ST_RUN;
        end
      end
      default: begin
        state_next = ges_pkg::ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_active <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (start_acc) begin
        box_active <= start_ok;
      end else if (pix_acc && sts.at_last) begin
        box_active <= 1'b0;
      end
      if (load_res) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_ok) begin
      den <= DEN_W'(w_last_s) * DEN_W'(h_last_s);
      sum <= '0;
    end else if (sts.sq_valid) begin
      sum <= sum_next;
    end
    if (load_res) begin
      if (start_acc) begin
        sharpness <= '0;
        status    <= oob ? ges_pkg::STAT_BOUNDS : ges_pkg::STAT_DEGEN;
      end else begin
        sharpness <= quotient;
        status    <= ges_pkg::STAT_OK;
      end
    end
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid;
  assign out_ch.sharpness = sharpness;
  assign out_ch.status    = status;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_res |-> (!out_valid || out_ch.ready))
    else $error("result register loaded while holding an untaken result");

  a_box_closed_in_div: assert property (@(posedge clk) disable iff (rst)
    (state != ges_pkg::ST_RUN) |-> !box_active)
    else $error("box still open while the division runs");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ges_pkg::ST_DIV))
    else $error("divider finished outside the division phase");

  a_last_sum: assert property (@(posedge clk) disable iff (rst)
    (state == ges_pkg::ST_SUM) |-> sts.sq_valid)
    else $error("last pixel gradients missing when the division starts");
`endif

endmodule

FILE: dv/gradient_energy_sharpness_test.sv
`timescale 1ns / 100ps

module gradient_energy_sharpness_test;

  localparam int unsigned LINE_DEPTH  = 64;
  localparam int unsigned ROW_LIMIT   = 1024;
  localparam int unsigned SETTLE_CYC  = 60;
  localparam int unsigned CYCLE_LIMIT = 300000;

  class focus_scoreboard;
    typedef struct {
      logic [ges_pkg::SHARP_W-1:0] sharpness;
      ges_pkg::status_t            status;
    } score_t;

    score_t                      expected_scores[$];
    int unsigned                 errors;
    logic [ges_pkg::BOX_W_W-1:0] box_w_reg;
    logic [ges_pkg::BOX_H_W-1:0] box_h_reg;
    logic [ges_pkg::WIN_W-1:0]   win_w_reg;
    logic [ges_pkg::WIN_W-1:0]   win_h_reg;
    logic [15:0]                 line_buf[LINE_DEPTH];
    logic [15:0]                 prev_pixel;
    logic [ges_pkg::SUM_W-1:0]   energy;
    int unsigned                 col;
    int unsigned                 row;
    int unsigned                 cols;
    int unsigned                 rows;
    bit                          box_open;

    function new();
      box_w_reg  = ges_pkg::BOX_W_RESET;
      box_h_reg  = ges_pkg::BOX_H_RESET;
      win_w_reg  = ges_pkg::WIN_RESET;
      win_h_reg  = ges_pkg::WIN_RESET;
      prev_pixel = '0;
      energy     = '0;
      col        = 0;
      row        = 0;
      cols       = 1;
      rows       = 1;
      box_open   = 0;
      errors     = 0;
    endfunction

    function int unsigned odd_size(int unsigned v, int unsigned limit);
      int unsigned s;
      int unsigned cap;
      s = v;
      cap = (limit - 2) | 1;
      if (s % 2 == 0) s++;
      if (s > cap) s = cap;
      return s;
    endfunction

    function longint unsigned grad_sq(logic [15:0] a, logic [15:0] b);
      longint unsigned d;
      d = (a >= b) ? longint'(a - b) : longint'(b - a);
      return d * d;
    endfunction

    function void set_reg(ges_pkg::cfg_reg_t r, logic [ges_pkg::CFG_DATA_W-1:0] val);
      case (r)
        ges_pkg::REG_BOX_WIDTH:     box_w_reg = val[ges_pkg::BOX_W_W-1:0];
        ges_pkg::REG_BOX_HEIGHT:    box_h_reg = val[ges_pkg::BOX_H_W-1:0];
        ges_pkg::REG_WINDOW_WIDTH:  win_w_reg = val[ges_pkg::WIN_W-1:0];
        ges_pkg::REG_WINDOW_HEIGHT: win_h_reg = val[ges_pkg::WIN_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_scores.size();
    endfunction

    function void note_item(ges_pkg::mode_t m, logic [ges_pkg::CXY_W-1:0] cx,
                            logic [ges_pkg::CXY_W-1:0] cy, logic [15:0] pix);
      int                w;
      int                h;
      int                hw;
      int                hh;
      int                x;
      int                y;
      longint unsigned   quot;
      score_t            s;
      if (m == ges_pkg::MODE_START) begin
        w = odd_size(box_w_reg, LINE_DEPTH);
        h = odd_size(box_h_reg, ROW_LIMIT);
        hw = w / 2;
        hh = h / 2;
        x = cx;
        y = cy;
        box_open = 0;
        s.sharpness = '0;
        if (x - hw < 0 || x + hw >= int'(win_w_reg) ||
            y - hh < 0 || y + hh >= int'(win_h_reg)) begin
          s.status = ges_pkg::STAT_BOUNDS;
          expected_scores.push_back(s);
        end else if (w == 1 || h == 1) begin
          s.status = ges_pkg::STAT_DEGEN;
          expected_scores.push_back(s);
        end else begin
          cols = w;
          rows = h;
          col = 0;
          row = 0;
          energy = '0;
          prev_pixel = '0;
          box_open = 1;
        end
        return;
      end
      if (!box_open) return;
      if (col >= 1 && row + 1 < rows) begin
        energy += ges_pkg::SUM_W'(grad_sq(pix, prev_pixel));
      end
      if (row >= 1 && col + 1 < cols) begin
        energy += ges_pkg::SUM_W'(grad_sq(pix, line_buf[col]));
      end
      line_buf[col] = pix;
      prev_pixel = pix;
      if (col + 1 >= cols) begin
        col = 0;
        if (row + 1 >= rows) begin
          box_open = 0;
          row = 0;
          quot = energy / (longint'(cols - 1) * longint'(rows - 1));
          s.sharpness = quot[ges_pkg::SHARP_W-1:0];
          s.status = ges_pkg::STAT_OK;
          expected_scores.push_back(s);
        end else begin
          row++;
        end
      end else begin
        col++;
      end
    endfunction

    function void check_score(logic [ges_pkg::SHARP_W-1:0] sharp,
                              logic [ges_pkg::STAT_W-1:0] stat);
      score_t e;
      if (expected_scores.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: sharpness %0d status %0d", $time, sharp, stat);
        return;
      end
      e = expected_scores.pop_front();
      if (sharp !== e.sharpness) begin
        errors++;
        $display("%0t: sharpness mismatch: expected %0d, actual %0d", $time,
                 e.sharpness, sharp);
      end
      if (stat !== e.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, e.status, stat);
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_write;
  logic [ges_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ges_pkg::CFG_DATA_W-1:0] cfg_data;
  int unsigned                    send_idle_pct = 37;
  int unsigned                    recv_idle_pct = 48;
  int unsigned                    cycles = 0;
  focus_scoreboard                sb;

  ges_in_if in_ch();
  ges_out_if out_ch();

  gradient_energy_sharpness dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Results are checked before the same edge's input transfer is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) sb.check_score(out_ch.sharpness, out_ch.status);
      if (in_ch.valid && in_ch.ready) begin
        sb.note_item(ges_pkg::mode_t'(in_ch.mode), in_ch.center_x, in_ch.center_y,
                     in_ch.pixel_value);
      end
    end
  end

  function automatic logic [15:0] pick_pixel();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  task automatic send_item(input ges_pkg::mode_t m, input logic [ges_pkg::CXY_W-1:0] cx,
                           input logic [ges_pkg::CXY_W-1:0] cy, input logic [15:0] pix);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= m;
    in_ch.center_x    <= cx;
    in_ch.center_y    <= cy;
    in_ch.pixel_value <= pix;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_start(input int cx, input int cy);
    send_item(ges_pkg::MODE_START, ges_pkg::CXY_W'(cx), ges_pkg::CXY_W'(cy),
              16'($urandom));
  endtask

  task automatic send_pixels(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      send_item(ges_pkg::MODE_PIXEL, ges_pkg::CXY_W'($urandom), ges_pkg::CXY_W'($urandom),
                pick_pixel());
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic configure(input int unsigned bw, input int unsigned bh,
                           input int unsigned ww, input int unsigned wh);
    ges_pkg::cfg_reg_t              regs[4] = '{ges_pkg::REG_BOX_WIDTH,
                                                ges_pkg::REG_BOX_HEIGHT,
                                                ges_pkg::REG_WINDOW_WIDTH,
                                                ges_pkg::REG_WINDOW_HEIGHT};
    logic [ges_pkg::CFG_DATA_W-1:0] vals[4];
    vals[0] = ges_pkg::CFG_DATA_W'(bw);
    vals[1] = ges_pkg::CFG_DATA_W'(bh);
    vals[2] = ges_pkg::CFG_DATA_W'(ww);
    vals[3] = ges_pkg::CFG_DATA_W'(wh);
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      sb.set_reg(regs[i], vals[i]);
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned target);
    int unsigned bw;
    int unsigned bh;
    int unsigned w;
    int unsigned h;
    int unsigned ww;
    int unsigned wh;
    int unsigned sent;
    int unsigned pick;
    int unsigned n;
    int          hw;
    int          hh;
    bit          wide;
    bit          drained;
    wide = ($urandom_range(0, 4) == 0);
    bw = wide ? $urandom_range(10, 63) : $urandom_range(0, 9);
    if (wide) bh = $urandom_range(0, 5);
    else bh = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 9);
    w = sb.odd_size(bw, LINE_DEPTH);
    h = sb.odd_size(bh, ROW_LIMIT);
    ww = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8192) : $urandom_range(w, w + 40);
    wh = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8192) : $urandom_range(h, h + 40);
    configure(bw, bh, ww, wh);
    hw = w / 2;
    hh = h / 2;
    sent = 0;
    drained = 0;
    while (sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70 && ww >= w && wh >= h) begin
        send_start($urandom_range(hw, ww - 1 - hw), $urandom_range(hh, wh - 1 - hh));
        n = w * h;
        if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n - 1);
        send_pixels(n);
        sent += 1 + n;
        if (!drained) begin
          drain();
          drained = 1;
        end
      end else if (pick < 85) begin
        send_start($urandom_range(0, 8191), $urandom_range(0, 8191));
        sent++;
      end else if (pick < 95) begin
        send_start($urandom_range(0, 1) ? hw - int'($urandom_range(0, 1))
                                        : int'(ww) - 1 - hw + int'($urandom_range(0, 1)),
                   $urandom_range(0, 1) ? hh - int'($urandom_range(0, 1))
                                        : int'(wh) - 1 - hh + int'($urandom_range(0, 1)));
        sent++;
      end else begin
        n = $urandom_range(1, 3);
        send_pixels(n);
        sent += n;
      end
    end
    settle();
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = ges_pkg::MODE_START;
    in_ch.center_x = '0;
    in_ch.center_y = '0;
    in_ch.pixel_value = '0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(ges_pkg::MODE_PIXEL, '1, '1, 16'hFFFF);
    send_start(6, 7);
    send_start(7, 6);
    send_start(1017, 7);
    send_start(7, 1017);
    send_start(1016, 1016);
    send_item(ges_pkg::MODE_PIXEL, '0, '0, 16'h1234);
    send_start(7, 7);
    settle();

    configure(2, 2, 8192, 8192);
    send_start(8191, 8191);
    send_start(0, 0);
    send_start(8190, 8190);
    for (int i = 0; i < 9; i++) begin
      send_item(ges_pkg::MODE_PIXEL, '0, '0, (i % 2 == 1) ? 16'hFFFF : 16'h0000);
    end
    settle();

    configure(0, 2, 5, 5);
    send_start(2, 2);
    send_start(5, 2);
    settle();

    configure(0, 0, 1, 1);
    send_start(0, 0);
    send_start(0, 1);
    settle();

    configure(62, 4, 63, 5);
    send_start(31, 2);
    send_pixels(63 * 5);
    settle();

    configure(2, 1022, 3, 1023);
    send_start(1, 511);
    send_pixels(90);
    send_start(1, 510);
    settle();

    for (int r = 0; r < 3; r++) begin
      send_idle_pct = (r == 0) ? 37 : (r == 1) ? 48 : 0;
      recv_idle_pct = (r == 0) ? 48 : (r == 1) ? 37 : 0;
      repeat (4) run_phase(70);
    end

    settle();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
